// ===== src/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define BFK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define BFK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/bfk_pkg.sv =====
package bfk_pkg;

  localparam int QFRAC = 14;
  localparam int MFRAC = 16;
  localparam int POS_FRAC_BITS = 16;

  typedef enum logic {
    OP_DEFINE = 1'b0,
    OP_POSE   = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  // one bone table row: parent, offset, orientation offset
  typedef struct packed {
    logic signed [8:0]  parent;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    quat_t              rot;
  } bone_def_t;

  // one world transform row
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    quat_t              rot;
  } world_t;

  localparam int DEF_W   = $bits(bone_def_t);
  localparam int WORLD_W = $bits(world_t);

  // round to nearest, ties up, by n bits (arithmetic shift floors)
  function automatic logic signed [47:0] rnd_shift(input logic signed [47:0] v,
                                                   input int n);
    logic signed [47:0] t;
    begin
      t = v + (48'sd1 <<< (n - 1));
      return t >>> n;
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    begin
      if (v > 48'sd32767) return 16'sh7fff;
      else if (v < -48'sd32768) return 16'sh8000;
      else return v[15:0];
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    begin
      if (v > 48'sd2147483647) return 32'sh7fffffff;
      else if (v < -48'sd2147483648) return 32'sh80000000;
      else return v[31:0];
    end
  endfunction

endpackage

// ===== src/bone_forward_kinematics_unit.sv =====
// bone forward kinematics unit
// input channel in_*: one request per bone, operation selects define or pose;
// define stores parent, offset and orientation offset, pose computes world
// position and rotation from the parent's stored world transform
// output channel out_*: exactly one result per request, in order
// a define, or a request with an out-of-range bone, passes S_RD1 and S_OUT
// before out_valid; a pose passes S_RD1, S_RD2, S_LOC, S_MAT and S_WB: read
// of both tables, local rotation product, matrix stage, world product
// the block holds one request at a time, set by the table read-modify-write
// loop, so a new request is taken once the previous result has been taken
// or is being taken in the same cycle
// reset clears control only; table contents stay undefined until written
// while a result waits with out_ready low, it holds in the output register
// and in_ready stays low
module bone_forward_kinematics_unit #(
  parameter int MAX_BONES     = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [7:0]         in_bone_index,
  input  logic signed [8:0]  in_parent_index,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_result_bone,
  output logic               out_status,
  output logic signed [31:0] out_world_pos_x,
  output logic signed [31:0] out_world_pos_y,
  output logic signed [31:0] out_world_pos_z,
  output logic signed [15:0] out_world_rot_w,
  output logic signed [15:0] out_world_rot_x,
  output logic signed [15:0] out_world_rot_y,
  output logic signed [15:0] out_world_rot_z
);

  `include "assert_macros.svh"

  localparam int AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  // wide enough to hold MAX_BONES itself for the range compare
  localparam int BW = (AW >= 8) ? AW + 1 : 9;

  typedef enum logic [2:0] {
    S_IDLE, S_RD1, S_RD2, S_LOC, S_MAT, S_WB, S_OUT
  } state_t;

  state_t state_r;
  logic   op_r;
  logic [7:0] bone_r;
  logic signed [8:0] par_in_r;
  logic signed [31:0] vx_r, vy_r, vz_r;
  bfk_pkg::quat_t q_r, lr_r;
  logic signed [31:0] lpx_r, lpy_r, lpz_r;
  logic reject, root_r;
  logic [AW-1:0] par_addr_r;

  logic [bfk_pkg::DEF_W-1:0]   def_rdata;
  logic [bfk_pkg::WORLD_W-1:0] world_rdata;
  bfk_pkg::bone_def_t def_row, def_wrow;
  bfk_pkg::world_t    world_row, world_wrow;
  logic def_we, world_we;
  logic [AW-1:0] def_raddr, world_raddr, waddr;

  bfk_pkg::quat_t qa, qb, qprod;
  logic signed [31:0] rx, ry, rz;

  logic in_fire, out_fire;
  logic [BW-1:0] bone_ext;
  logic in_range;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = (state_r == S_IDLE) && (!out_valid || out_ready);
  assign bone_ext = BW'(bone_r);
  assign in_range = (bone_ext < BW'(MAX_BONES));
  assign waddr    = bone_ext[AW-1:0];
  assign def_row   = bfk_pkg::bone_def_t'(def_rdata);
  assign world_row = bfk_pkg::world_t'(world_rdata);
  assign def_raddr   = bone_ext[AW-1:0];
  assign world_raddr = par_addr_r;

  assign def_wrow.parent = (par_in_r < 0) ? -9'sd1 : par_in_r;
  assign def_wrow.ox  = vx_r;
  assign def_wrow.oy  = vy_r;
  assign def_wrow.oz  = vz_r;
  assign def_wrow.rot = q_r;
  assign def_we = (state_r == S_RD1) && (op_r == bfk_pkg::OP_DEFINE) && !reject &&
                  in_range;

  // first product: rotoff*rot, second: parent_rot*local
  assign qa = (state_r == S_LOC) ? def_row.rot : world_row.rot;
  assign qb = (state_r == S_LOC) ? q_r : lr_r;

  bfk_math u_math (
    .clk(clk), .qa(qa), .qb(qb), .qprod(qprod),
    .mq(world_row.rot), .px(lpx_r), .py(lpy_r), .pz(lpz_r),
    .bx(world_row.px), .by(world_row.py), .bz(world_row.pz),
    .rx(rx), .ry(ry), .rz(rz)
  );

  always_comb begin
    world_wrow.px = root_r ? lpx_r : rx;
    world_wrow.py = root_r ? lpy_r : ry;
    world_wrow.pz = root_r ? lpz_r : rz;
    world_wrow.rot = root_r ? lr_r : qprod;
  end
  assign world_we = (state_r == S_WB);

  bfk_ram #(.WIDTH(bfk_pkg::DEF_W), .DEPTH(MAX_BONES)) u_def_ram (
    .clk(clk), .we(def_we), .waddr(waddr), .wdata(def_wrow),
    .raddr(def_raddr), .rdata(def_rdata)
  );

  bfk_ram #(.WIDTH(bfk_pkg::WORLD_W), .DEPTH(MAX_BONES)) u_world_ram (
    .clk(clk), .we(world_we), .waddr(waddr), .wdata(world_wrow),
    .raddr(world_raddr), .rdata(world_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r     <= in_operation;
            bone_r   <= in_bone_index;
            par_in_r <= in_parent_index;
            vx_r <= in_vec_x;
            vy_r <= in_vec_y;
            vz_r <= in_vec_z;
            q_r  <= '{in_quat_w, in_quat_x, in_quat_y, in_quat_z};
            state_r <= S_RD1;
          end
        end
        S_RD1: begin
          // reject check; define row written this cycle when legal
          if (!in_range || (op_r == bfk_pkg::OP_DEFINE && !reject)) begin
            state_r <= S_OUT;
          end else if (op_r == bfk_pkg::OP_DEFINE) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_RD2;
          end
        end
        S_RD2: begin
          // bone row valid now, fetch the parent world row
          lpx_r <= bfk_pkg::sat32(48'(vx_r) + 48'(def_row.ox));
          lpy_r <= bfk_pkg::sat32(48'(vy_r) + 48'(def_row.oy));
          lpz_r <= bfk_pkg::sat32(48'(vz_r) + 48'(def_row.oz));
          root_r <= (def_row.parent < 0) ||
                    (BW'(unsigned'(def_row.parent[7:0])) >= BW'(MAX_BONES));
          par_addr_r <= AW'(unsigned'(def_row.parent[7:0]));
          state_r <= S_LOC;
        end
        S_LOC: begin
          lr_r <= qprod;
          state_r <= S_MAT;
        end
        S_MAT: state_r <= S_WB;
        S_WB: begin
          out_world_pos_x <= world_wrow.px;
          out_world_pos_y <= world_wrow.py;
          out_world_pos_z <= world_wrow.pz;
          out_world_rot_w <= world_wrow.rot.w;
          out_world_rot_x <= world_wrow.rot.x;
          out_world_rot_y <= world_wrow.rot.y;
          out_world_rot_z <= world_wrow.rot.z;
          out_result_bone <= bone_r;
          out_status <= 1'b0;
          out_valid <= 1'b1;
          state_r <= S_IDLE;
        end
        S_OUT: begin
          out_world_pos_x <= '0;
          out_world_pos_y <= '0;
          out_world_pos_z <= '0;
          out_world_rot_w <= '0;
          out_world_rot_x <= '0;
          out_world_rot_y <= '0;
          out_world_rot_z <= '0;
          out_result_bone <= bone_r;
          out_status <= reject || !in_range;
          out_valid <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  // rejection when parent not below bone, computed in parallel with state
  always_comb begin
    reject = (op_r == bfk_pkg::OP_DEFINE) &&
             ($signed({1'b0, bone_r}) <= par_in_r);
  end

  `BFK_ASSERT_IMP(a_one_item, clk, rst_n, out_valid && !out_ready, !in_ready)
  `BFK_ASSERT_NXT(a_wb_out, clk, rst_n, state_r == S_WB, out_valid)
  `BFK_ASSERT_IMP(a_no_both_we, clk, rst_n, def_we, !world_we)

endmodule

// ===== src/bfk_ram.sv =====
module bfk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bfk_math.sv =====
// multiply unit: four 16x16 products per quaternion component, 32x22 per matrix product
module bfk_math (
  input  logic                clk,
  input  bfk_pkg::quat_t      qa,
  input  bfk_pkg::quat_t      qb,
  output bfk_pkg::quat_t      qprod,
  input  bfk_pkg::quat_t      mq,
  input  logic signed [31:0]  px,
  input  logic signed [31:0]  py,
  input  logic signed [31:0]  pz,
  input  logic signed [31:0]  bx,
  input  logic signed [31:0]  by,
  input  logic signed [31:0]  bz,
  output logic signed [31:0]  rx,
  output logic signed [31:0]  ry,
  output logic signed [31:0]  rz
);

  logic signed [47:0] qs [4];
  logic signed [47:0] m [9];
  logic signed [47:0] mr [9];
  logic signed [31:0] xx, yy, zz;
  logic signed [47:0] s [3];
  logic signed [21:0] mr_r [9];
  logic signed [31:0] px_r, py_r, pz_r;

  // quaternion product, combinational on registered operands
  always_comb begin
    qs[0] = 48'(qa.w * qb.w) - 48'(qa.x * qb.x) - 48'(qa.y * qb.y) - 48'(qa.z * qb.z);
    qs[1] = 48'(qa.w * qb.x) + 48'(qa.x * qb.w) + 48'(qa.y * qb.z) - 48'(qa.z * qb.y);
    qs[2] = 48'(qa.w * qb.y) - 48'(qa.x * qb.z) + 48'(qa.y * qb.w) + 48'(qa.z * qb.x);
    qs[3] = 48'(qa.w * qb.z) + 48'(qa.x * qb.y) - 48'(qa.y * qb.x) + 48'(qa.z * qb.w);
    qprod.w = bfk_pkg::sat16(bfk_pkg::rnd_shift(qs[0], bfk_pkg::QFRAC));
    qprod.x = bfk_pkg::sat16(bfk_pkg::rnd_shift(qs[1], bfk_pkg::QFRAC));
    qprod.y = bfk_pkg::sat16(bfk_pkg::rnd_shift(qs[2], bfk_pkg::QFRAC));
    qprod.z = bfk_pkg::sat16(bfk_pkg::rnd_shift(qs[3], bfk_pkg::QFRAC));
  end

  // rotation matrix in q28, rounded to q16 (unnormalized input needs 22 bits)
  always_comb begin
    xx = 32'(mq.x * mq.x);
    yy = 32'(mq.y * mq.y);
    zz = 32'(mq.z * mq.z);
    m[0] = (48'sd1 <<< 28) - 2 * (48'(yy) + 48'(zz));
    m[1] = 2 * (48'(mq.x * mq.y) - 48'(mq.w * mq.z));
    m[2] = 2 * (48'(mq.x * mq.z) + 48'(mq.w * mq.y));
    m[3] = 2 * (48'(mq.x * mq.y) + 48'(mq.w * mq.z));
    m[4] = (48'sd1 <<< 28) - 2 * (48'(xx) + 48'(zz));
    m[5] = 2 * (48'(mq.y * mq.z) - 48'(mq.w * mq.x));
    m[6] = 2 * (48'(mq.x * mq.z) - 48'(mq.w * mq.y));
    m[7] = 2 * (48'(mq.y * mq.z) + 48'(mq.w * mq.x));
    m[8] = (48'sd1 <<< 28) - 2 * (48'(xx) + 48'(yy));
    for (int i = 0; i < 9; i++) begin
      mr[i] = bfk_pkg::rnd_shift(m[i], 2 * bfk_pkg::QFRAC - bfk_pkg::MFRAC);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      mr_r[i] <= mr[i][21:0];
    end
    px_r <= px;
    py_r <= py;
    pz_r <= pz;
  end

  logic signed [63:0] s64 [3];
  logic signed [47:0] t [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s64[i] = 64'(mr_r[3*i] * px_r) + 64'(mr_r[3*i+1] * py_r) + 64'(mr_r[3*i+2] * pz_r);
      s64[i] = s64[i] + (64'sd1 <<< (bfk_pkg::MFRAC - 1));
      s64[i] = s64[i] >>> bfk_pkg::MFRAC;
      t[i] = s64[i][47:0];
    end
    s[0] = t[0] + 48'(bx);
    s[1] = t[1] + 48'(by);
    s[2] = t[2] + 48'(bz);
    rx = bfk_pkg::sat32(s[0]);
    ry = bfk_pkg::sat32(s[1]);
    rz = bfk_pkg::sat32(s[2]);
  end

endmodule

// ===== bench/tb_bone_forward_kinematics_unit.sv =====
`default_nettype none

typedef struct {
  bfk_pkg::op_t       op;
  logic [7:0]         bone;
  logic signed [8:0]  parent;
  logic signed [31:0] vx, vy, vz;
  bfk_pkg::quat_t     q;
} bone_request_t;

typedef struct {
  logic [7:0]         bone;
  logic               status;
  logic signed [31:0] px, py, pz;
  bfk_pkg::quat_t     rot;
} bone_result_t;

class kinematics_scoreboard;
  int             errors;
  int             table_size;
  int             parent_of[256];
  longint         off_x[256], off_y[256], off_z[256];
  bfk_pkg::quat_t off_rot[256];
  longint         world_x[256], world_y[256], world_z[256];
  bfk_pkg::quat_t world_rot[256];
  bone_result_t   expected_results[$];

  function new(int max_bones);
    table_size = max_bones;
    errors = 0;
  endfunction

  function longint round_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function bfk_pkg::quat_t quat_product(bfk_pkg::quat_t a, bfk_pkg::quat_t b);
    longint aw, ax, ay, az, bw, bx, by, bz;
    bfk_pkg::quat_t r;
    aw = a.w; ax = a.x; ay = a.y; az = a.z;
    bw = b.w; bx = b.x; by = b.y; bz = b.z;
    r.w = clamp16(round_shift(aw * bw - ax * bx - ay * by - az * bz, bfk_pkg::QFRAC));
    r.x = clamp16(round_shift(aw * bx + ax * bw + ay * bz - az * by, bfk_pkg::QFRAC));
    r.y = clamp16(round_shift(aw * by - ax * bz + ay * bw + az * bx, bfk_pkg::QFRAC));
    r.z = clamp16(round_shift(aw * bz + ax * by - ay * bx + az * bw, bfk_pkg::QFRAC));
    return r;
  endfunction

  // world position of a child: parent position plus parent rotation applied to p
  function void place_child(bfk_pkg::quat_t q, longint p[3], longint origin[3],
                            ref longint res[3]);
    longint w, x, y, z, unit, s;
    longint m[9];
    w = q.w; x = q.x; y = q.y; z = q.z;
    unit = 64'sd1 <<< (2 * bfk_pkg::QFRAC);
    m[0] = unit - 2 * (y * y + z * z);
    m[1] = 2 * (x * y - w * z);
    m[2] = 2 * (x * z + w * y);
    m[3] = 2 * (x * y + w * z);
    m[4] = unit - 2 * (x * x + z * z);
    m[5] = 2 * (y * z - w * x);
    m[6] = 2 * (x * z - w * y);
    m[7] = 2 * (y * z + w * x);
    m[8] = unit - 2 * (x * x + y * y);
    for (int i = 0; i < 9; i++) m[i] = round_shift(m[i], 2 * bfk_pkg::QFRAC - bfk_pkg::MFRAC);
    for (int i = 0; i < 3; i++) begin
      s = m[3*i] * p[0] + m[3*i+1] * p[1] + m[3*i+2] * p[2];
      res[i] = clamp32(origin[i] + round_shift(s, bfk_pkg::MFRAC));
    end
  endfunction

  function void note_request(bone_request_t req);
    bone_result_t r;
    longint p[3], origin[3], wp[3];
    bfk_pkg::quat_t lr;
    int b, par;
    r.bone = req.bone;
    r.status = 1'b0;
    r.px = '0; r.py = '0; r.pz = '0; r.rot = '0;
    b = req.bone;
    if (b >= table_size) begin
      r.status = 1'b1;
    end else if (req.op == bfk_pkg::OP_DEFINE) begin
      if (int'(req.parent) >= b) begin
        r.status = 1'b1;
      end else begin
        parent_of[b] = (req.parent < 0) ? -1 : int'(req.parent);
        off_x[b] = req.vx; off_y[b] = req.vy; off_z[b] = req.vz;
        off_rot[b] = req.q;
      end
    end else begin
      par = parent_of[b];
      p[0] = clamp32(longint'(req.vx) + off_x[b]);
      p[1] = clamp32(longint'(req.vy) + off_y[b]);
      p[2] = clamp32(longint'(req.vz) + off_z[b]);
      lr = quat_product(off_rot[b], req.q);
      if (par >= 0) begin
        origin[0] = world_x[par]; origin[1] = world_y[par]; origin[2] = world_z[par];
        place_child(world_rot[par], p, origin, wp);
        r.rot = quat_product(world_rot[par], lr);
      end else begin
        wp = p;
        r.rot = lr;
      end
      r.px = wp[0][31:0]; r.py = wp[1][31:0]; r.pz = wp[2][31:0];
      world_x[b] = wp[0]; world_y[b] = wp[1]; world_z[b] = wp[2];
      world_rot[b] = r.rot;
    end
    expected_results.push_back(r);
  endfunction

  task report(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  task check_result(bone_result_t got);
    bone_result_t e;
    if (expected_results.size() == 0) begin
      report("unexpected result for bone", got.bone, -1);
      return;
    end
    e = expected_results.pop_front();
    if (got.bone !== e.bone) report("result_bone", got.bone, e.bone);
    if (got.status !== e.status) report("status", got.status, e.status);
    if (got.px !== e.px) report("world_pos_x", got.px, e.px);
    if (got.py !== e.py) report("world_pos_y", got.py, e.py);
    if (got.pz !== e.pz) report("world_pos_z", got.pz, e.pz);
    if (got.rot.w !== e.rot.w) report("world_rot_w", got.rot.w, e.rot.w);
    if (got.rot.x !== e.rot.x) report("world_rot_x", got.rot.x, e.rot.x);
    if (got.rot.y !== e.rot.y) report("world_rot_y", got.rot.y, e.rot.y);
    if (got.rot.z !== e.rot.z) report("world_rot_z", got.rot.z, e.rot.z);
  endtask

  function int outstanding();
    return expected_results.size();
  endfunction
endclass

module tb_bone_forward_kinematics_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BONES = 256;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_operation = 1'b0;
  logic [7:0]         in_bone_index = '0;
  logic signed [8:0]  in_parent_index = '0;
  logic signed [31:0] in_vec_x = '0, in_vec_y = '0, in_vec_z = '0;
  logic signed [15:0] in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_result_bone;
  logic               out_status;
  logic signed [31:0] out_world_pos_x, out_world_pos_y, out_world_pos_z;
  logic signed [15:0] out_world_rot_w, out_world_rot_x, out_world_rot_y, out_world_rot_z;

  kinematics_scoreboard board = new(BONES);
  bit   long_hold_req = 0;
  bit   gen_defined[256];
  bit   gen_posed[256];
  int   gen_parent[256];

  bone_forward_kinematics_unit #(.MAX_BONES(BONES)) DUT (.*);

  always #5 clk = ~clk;

  initial begin
    #20ms;
    $display("tb_bone_forward_kinematics_unit: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    bone_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.bone = out_result_bone;
      got.status = out_status;
      got.px = out_world_pos_x; got.py = out_world_pos_y; got.pz = out_world_pos_z;
      got.rot.w = out_world_rot_w; got.rot.x = out_world_rot_x;
      got.rot.y = out_world_rot_y; got.rot.z = out_world_rot_z;
      board.check_result(got);
    end
  end

  // result side: random stalls, quiet stretches, one long hold-off on request
  initial begin
    int stall_left, cyc;
    stall_left = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (long_hold_req) begin
        long_hold_req = 0;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ((cyc % 1000) < 200 || $urandom_range(0, 99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(0, 3);
        out_ready <= 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic signed [31:0] pick_vec();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
    endcase
  endfunction

  function automatic bfk_pkg::quat_t pick_quat();
    bfk_pkg::quat_t q;
    if ($urandom_range(0, 3) == 0) begin
      q = {$urandom, $urandom};
    end else begin
      q.w = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
      q.x = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
      q.y = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
      q.z = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
    end
    return q;
  endfunction

  function automatic bone_request_t make_request(bfk_pkg::op_t op, int bone, int parent,
                                                 int vx, int vy, int vz,
                                                 int qw, int qx, int qy, int qz);
    bone_request_t req;
    req.op = op; req.bone = 8'(bone); req.parent = 9'(parent);
    req.vx = vx; req.vy = vy; req.vz = vz;
    req.q.w = 16'(qw); req.q.x = 16'(qx); req.q.y = 16'(qy); req.q.z = 16'(qz);
    return req;
  endfunction

  task automatic issue(bone_request_t req, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= req.op;
    in_bone_index <= req.bone;
    in_parent_index <= req.parent;
    in_vec_x <= req.vx; in_vec_y <= req.vy; in_vec_z <= req.vz;
    in_quat_w <= req.q.w; in_quat_x <= req.q.x;
    in_quat_y <= req.q.y; in_quat_z <= req.q.z;
    do @(posedge clk); while (!in_ready);
    board.note_request(req);
    if (req.op == bfk_pkg::OP_DEFINE && int'(req.parent) < int'(req.bone)) begin
      gen_defined[req.bone] = 1;
      gen_parent[req.bone] = req.parent < 0 ? -1 : int'(req.parent);
    end else if (req.op == bfk_pkg::OP_POSE) begin
      gen_posed[req.bone] = 1;
    end
  endtask

  function automatic bit can_pose(int b);
    return gen_defined[b] && (gen_parent[b] < 0 || gen_posed[gen_parent[b]]);
  endfunction

  task automatic random_request();
    bone_request_t req;
    int b, tries;
    bit posing;
    posing = 0;
    if ($urandom_range(0, 99) < 60) begin
      for (tries = 0; tries < 20 && !posing; tries++) begin
        b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 31);
        posing = can_pose(b);
      end
    end
    if (!posing) begin
      b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 31);
    end
    req.op = posing ? bfk_pkg::OP_POSE : bfk_pkg::OP_DEFINE;
    req.bone = 8'(b);
    case ($urandom_range(0, 19))
      0, 1, 2: req.parent = 9'($urandom_range(b, 255));
      3, 4, 5: req.parent = 9'(-$signed(10'($urandom_range(1, 256))));
      default: req.parent = (b == 0) ? -9'sd1 : 9'($urandom_range(0, b - 1));
    endcase
    if (posing) req.parent = 9'($urandom);
    req.vx = pick_vec(); req.vy = pick_vec(); req.vz = pick_vec();
    req.q = pick_quat();
    issue(req, pick_gap());
  endtask

  initial begin
    int settle;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(make_request(bfk_pkg::OP_DEFINE, 0, -1, 0, 0, 0, 16384, 0, 0, 0), 0);
    issue(make_request(bfk_pkg::OP_POSE, 0, 0, 65536, -65536, 3, 16384, 0, 0, 0), 0);
    issue(make_request(bfk_pkg::OP_DEFINE, 1, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       0, 16384, 0, 0), 0);
    issue(make_request(bfk_pkg::OP_POSE, 1, 0, 32'h7fffffff, 1, -1, 11585, 0, 11585, 0), 0);
    issue(make_request(bfk_pkg::OP_DEFINE, 2, 1, 32'h80000000, 32'h80000000, 32'h80000000,
                       32767, 32767, 32767, 32767), 0);
    issue(make_request(bfk_pkg::OP_POSE, 2, 0, 32'h80000000, 32'h80000000, 32'h80000000,
                       -32768, -32768, -32768, -32768), 0);
    issue(make_request(bfk_pkg::OP_DEFINE, 3, 3, 5, 5, 5, 16384, 0, 0, 0), 0);
    issue(make_request(bfk_pkg::OP_DEFINE, 0, 255, 5, 5, 5, 16384, 0, 0, 0), 0);
    issue(make_request(bfk_pkg::OP_DEFINE, 4, 200, 5, 5, 5, 16384, 0, 0, 0), 2);
    issue(make_request(bfk_pkg::OP_DEFINE, 254, -256, 100, -100, 7, 0, 0, 0, 16384), 0);
    issue(make_request(bfk_pkg::OP_DEFINE, 255, 254, -7, 8, 9, -16384, 0, 0, 0), 0);
    issue(make_request(bfk_pkg::OP_POSE, 254, 255, 1, 2, 3, 16384, 100, -100, 3), 0);
    issue(make_request(bfk_pkg::OP_POSE, 255, -1, 32'h40000000, 0, -5, 0, 0, 16384, 0), 0);
    issue(make_request(bfk_pkg::OP_DEFINE, 5, 2, 12345, -54321, 999, 0, 0, 0, 0), 0);
    issue(make_request(bfk_pkg::OP_POSE, 5, 0, -1, -1, -1, 16384, 0, 0, 0), 0);
    issue(make_request(bfk_pkg::OP_DEFINE, 6, -129, 0, 0, 0, 30000, -30000, 30000, -30000), 0);
    issue(make_request(bfk_pkg::OP_POSE, 6, 0, 65536, 65536, 65536, 30000, 30000, -30000, 1), 0);
    issue(make_request(bfk_pkg::OP_DEFINE, 7, 6, 65536, 0, 0, 16384, 0, 0, 0), 0);
    issue(make_request(bfk_pkg::OP_POSE, 7, 0, 0, 65536, 0, 16384, 0, 0, 0), 0);

    for (int n = 0; n < 1700; n++) begin
      if (n == 600) long_hold_req = 1;
      if (n == 1200) begin
        in_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge clk);
      end
      random_request();
    end
    in_valid <= 1'b0;

    settle = 0;
    while (board.outstanding() != 0 && settle < 100000) begin
      @(posedge clk);
      settle++;
    end
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("tb_bone_forward_kinematics_unit: PASS");
    end else begin
      $display("tb_bone_forward_kinematics_unit: FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire
